### design/swm_pkg.sv
// Shared constants, codes and types for the star wildcard matcher.
// Used by swm_walker and star_wildcard_match_capture_top; depends on nothing.
package swm_pkg;

	localparam int MAX_LEN   = 256;
	localparam int MAX_STARS = 20;

	localparam int LEN_W  = $clog2(MAX_LEN + 1);
	localparam int ADDR_W = $clog2(MAX_LEN);
	localparam int STAR_W = $clog2(MAX_STARS + 1);
	localparam int STOT_W = $clog2(MAX_STARS + 2);
	localparam int CAP_AW = (MAX_STARS > 1) ? $clog2(MAX_STARS) : 1;
	localparam int CAP_W  = 2 * LEN_W;

	localparam int IDX_W = 5;
	localparam int POS_W = 9;

	localparam logic [7:0] STAR_BYTE = 8'h2A;
	localparam logic [7:0] NUL_BYTE  = 8'h00;

	localparam logic MODE_PATTERN = 1'b0;
	localparam logic MODE_SUBJECT = 1'b1;

	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_LONG  = 2'd1,
		ERR_STARS = 2'd2
	} err_t;

	typedef enum logic [2:0] {
		T_IDLE,
		T_WALK,
		T_RESULT,
		T_CAP_RD,
		T_CAP_PUSH
	} top_state_t;

	typedef enum logic {
		W_IDLE,
		W_STEP
	} walk_state_t;

	// string byte write from the loader
	typedef struct packed {
		logic              pat_we;
		logic              sub_we;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} swm_load_t;

	// one finished capture entry
	typedef struct packed {
		logic              we;
		logic [CAP_AW-1:0] idx;
		logic [LEN_W-1:0]  start;
		logic [LEN_W-1:0]  count;
	} swm_cap_wr_t;

	// walk outcome, valid for one cycle with done
	typedef struct packed {
		logic              done;
		logic              matched;
		logic [STAR_W-1:0] ncap;
	} swm_walk_t;

endpackage

### design/swm_walker.sv
// Pattern and subject byte memories plus the backtracking walk over them.
// Depends on swm_pkg.
module swm_walker (
	input  logic                     clk,
	input  logic                     arst_n,
	input  swm_pkg::swm_load_t       load,
	input  logic [swm_pkg::LEN_W-1:0] plen_i,
	input  logic [swm_pkg::LEN_W-1:0] slen_i,
	input  logic                     start_i,
	output swm_pkg::swm_cap_wr_t     cap_wr,
	output swm_pkg::swm_walk_t       res
);
	import swm_pkg::*;

	logic [7:0] pat_mem [MAX_LEN];
	logic [7:0] sub_mem [MAX_LEN];
	logic [7:0] pd_q, sd_q;

	walk_state_t state_q, state_d;
	logic [LEN_W-1:0]  p_q, p_d, s_q, s_d;
	logic [LEN_W-1:0]  resume_q, resume_d, anchor_q, anchor_d;
	logic [LEN_W-1:0]  cur_begin_q, cur_begin_d, cur_count_q, cur_count_d;
	logic [STAR_W-1:0] n_q, n_d;
	logic              have_star_q, have_star_d;
	logic [7:0]        pc, sc;

	// read at the next position so the data is there for the next step
	always_ff @(posedge clk) begin
		if (load.pat_we) begin
			pat_mem[load.addr] <= load.data;
		end
		if (load.sub_we) begin
			sub_mem[load.addr] <= load.data;
		end
		pd_q <= pat_mem[p_d[ADDR_W-1:0]];
		sd_q <= sub_mem[s_d[ADDR_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= W_IDLE;
			p_q         <= '0;
			s_q         <= '0;
			resume_q    <= '0;
			anchor_q    <= '0;
			n_q         <= '0;
			have_star_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			p_q         <= p_d;
			s_q         <= s_d;
			resume_q    <= resume_d;
			anchor_q    <= anchor_d;
			n_q         <= n_d;
			have_star_q <= have_star_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_begin_q <= cur_begin_d;
		cur_count_q <= cur_count_d;
	end

	always_comb begin
		pc = (p_q < LEN_W'(plen_i)) ? pd_q : NUL_BYTE;
		sc = (s_q < LEN_W'(slen_i)) ? sd_q : NUL_BYTE;

		state_d     = state_q;
		p_d         = p_q;
		s_d         = s_q;
		resume_d    = resume_q;
		anchor_d    = anchor_q;
		n_d         = n_q;
		have_star_d = have_star_q;
		cur_begin_d = cur_begin_q;
		cur_count_d = cur_count_q;

		cap_wr.we    = 1'b0;
		cap_wr.idx   = CAP_AW'(n_q - 1'b1);
		cap_wr.start = cur_begin_q;
		cap_wr.count = cur_count_q;

		res.done    = 1'b0;
		res.matched = 1'b0;
		res.ncap    = n_q;

		unique case (state_q)
			W_IDLE: begin
				if (start_i) begin
					p_d         = '0;
					s_d         = '0;
					resume_d    = '0;
					anchor_d    = '0;
					n_d         = '0;
					have_star_d = 1'b0;
					state_d     = W_STEP;
				end
			end
			W_STEP: begin
				priority if (pc == STAR_BYTE) begin
					// open a new capture, retire the previous one
					cap_wr.we   = have_star_q;
					p_d         = p_q + 1'b1;
					resume_d    = p_q + 1'b1;
					anchor_d    = s_q;
					cur_begin_d = s_q;
					cur_count_d = '0;
					n_d         = n_q + 1'b1;
					have_star_d = 1'b1;
				end else if (pc == sc) begin
					if (pc == NUL_BYTE) begin
						cap_wr.we   = have_star_q;
						res.done    = 1'b1;
						res.matched = 1'b1;
						state_d     = W_IDLE;
					end else begin
						p_d = p_q + 1'b1;
						s_d = s_q + 1'b1;
					end
				end else if (sc == NUL_BYTE || !have_star_q) begin
					res.done = 1'b1;
					state_d  = W_IDLE;
				end else begin
					// let the latest star absorb one more byte
					p_d         = resume_q;
					anchor_d    = anchor_q + 1'b1;
					s_d         = anchor_q + 1'b1;
					cur_count_d = cur_count_q + 1'b1;
				end
			end
			default: begin
				state_d = W_IDLE;
			end
		endcase
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start_i |-> state_q == W_IDLE)
		else $error("walk started while busy");

	a_pos_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == W_STEP |-> (s_q <= LEN_W'(slen_i)) && (anchor_q <= s_q))
		else $error("subject position out of order");

	a_cap_has_star: assert property (@(posedge clk) disable iff (!arst_n)
		cap_wr.we |-> have_star_q && (n_q != '0))
		else $error("capture written with no open star");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res.done |=> state_q == W_IDLE)
		else $error("walk did not stop after done");

endmodule

### design/star_wildcard_match_capture_top.sv
// Top level of the star wildcard matcher: loader, capture memory, result register.
// Depends on swm_pkg and swm_walker.
//
//  channel | signals                          | beat carries
//  --------+----------------------------------+------------------------------------------
//  in      | in_valid, in_stall               | mode, byte_in
//  out     | out_valid, out_stall             | matched, error_code, capture_valid,
//          |                                  | capture_index, capture_start,
//          |                                  | capture_length, last_result
//
//  Flow: a subject terminator starts the walk, or gives an error result at once if a string
//  overflowed or the pattern holds too many stars. Each walk step compares against the byte
//  memories (one read port each); backtracking repeats steps, so the walk is bounded by about
//  (pattern length + 1) * (subject length + 1) steps. Then a single result beat, or per
//  capture beat a capture memory read, then a result register load.
//  Reset: arst_n clears control state and lengths; the byte and capture memories are not
//  cleared, since only written entries are ever read. No clearing pass.
//  Stalls: the result register holds its beat while out_stall is high; in_stall is high
//  from the terminator until the last result beat has entered the result register.
module star_wildcard_match_capture_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       mode,
	input  logic [7:0] byte_in,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       matched,
	output logic [1:0] error_code,
	output logic       capture_valid,
	output logic [4:0] capture_index,
	output logic [8:0] capture_start,
	output logic [8:0] capture_length,
	output logic       last_result
);
	import swm_pkg::*;

	top_state_t state_q, state_d;

	// string bookkeeping
	logic [LEN_W-1:0]  plen_q, slen_q;
	logic              ovf_q;
	logic [STOT_W-1:0] star_tot_q;

	// pending result and capture walk-out
	err_t              res_err_q;
	logic              res_match_q;
	logic [STAR_W-1:0] cap_n_q, k_q;

	// capture memory: {start, count} per star
	logic [CAP_W-1:0] cap_mem [MAX_STARS];
	logic [CAP_W-1:0] cap_rd_q;

	// result register
	logic             out_valid_q, matched_q, cap_valid_q, last_q;
	err_t             err_q;
	logic [IDX_W-1:0] cap_idx_q;
	logic [POS_W-1:0] cap_start_q, cap_len_q;

	swm_load_t   load;
	swm_cap_wr_t cap_wr;
	swm_walk_t   walk;

	logic in_acc, out_free, is_term, is_pat_byte, is_sub_byte;
	logic walk_start, clear_str, load_res, load_cap, cap_last;

	assign in_acc      = in_valid && !in_stall;
	assign out_free    = !out_valid_q || !out_stall;
	assign is_pat_byte = (mode == MODE_PATTERN) && (byte_in != NUL_BYTE);
	assign is_sub_byte = (mode == MODE_SUBJECT) && (byte_in != NUL_BYTE);
	assign is_term     = (mode == MODE_SUBJECT) && (byte_in == NUL_BYTE);
	assign cap_last    = (STAR_W'(k_q + 1'b1) == cap_n_q);

	// drop a byte once its store is full
	always_comb begin
		load.pat_we = in_acc && is_pat_byte && (plen_q < LEN_W'(MAX_LEN));
		load.sub_we = in_acc && is_sub_byte && (slen_q < LEN_W'(MAX_LEN));
		load.addr   = is_pat_byte ? plen_q[ADDR_W-1:0] : slen_q[ADDR_W-1:0];
		load.data   = byte_in;
	end

	swm_walker u_walker (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load),
		.plen_i  (plen_q),
		.slen_i  (slen_q),
		.start_i (walk_start),
		.cap_wr  (cap_wr),
		.res     (walk)
	);

	always_ff @(posedge clk) begin
		if (cap_wr.we) begin
			cap_mem[cap_wr.idx] <= {cap_wr.start, cap_wr.count};
		end
		cap_rd_q <= cap_mem[k_q[CAP_AW-1:0]];
	end

	// next state and handshake control
	always_comb begin
		state_d    = state_q;
		in_stall   = 1'b1;
		walk_start = 1'b0;
		clear_str  = 1'b0;
		load_res   = 1'b0;
		load_cap   = 1'b0;

		unique case (state_q)
			T_IDLE: begin
				in_stall = 1'b0;
				if (in_valid && is_term) begin
					if (ovf_q || (star_tot_q > STOT_W'(MAX_STARS))) begin
						clear_str = 1'b1;
						state_d   = T_RESULT;
					end else begin
						walk_start = 1'b1;
						state_d    = T_WALK;
					end
				end
			end
			T_WALK: begin
				if (walk.done) begin
					clear_str = 1'b1;
					if (walk.matched && (walk.ncap != '0)) begin
						state_d = T_CAP_RD;
					end else begin
						state_d = T_RESULT;
					end
				end
			end
			T_RESULT: begin
				if (out_free) begin
					load_res = 1'b1;
					state_d  = T_IDLE;
				end
			end
			T_CAP_RD: begin
				state_d = T_CAP_PUSH;
			end
			T_CAP_PUSH: begin
				if (out_free) begin
					load_cap = 1'b1;
					state_d  = cap_last ? T_IDLE : T_CAP_RD;
				end
			end
			default: begin
				state_d = T_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			plen_q      <= '0;
			slen_q      <= '0;
			ovf_q       <= 1'b0;
			star_tot_q  <= '0;
			res_err_q   <= ERR_NONE;
			res_match_q <= 1'b0;
			cap_n_q     <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			// load strings; count stars only up to one past the limit
			if (load.pat_we) begin
				plen_q <= plen_q + 1'b1;
				if (byte_in == STAR_BYTE && star_tot_q <= STOT_W'(MAX_STARS)) begin
					star_tot_q <= star_tot_q + 1'b1;
				end
			end
			if (load.sub_we) begin
				slen_q <= slen_q + 1'b1;
			end
			if (in_acc && (is_pat_byte || is_sub_byte) && !load.pat_we && !load.sub_we) begin
				ovf_q <= 1'b1;
			end

			// latch the error kind before the strings are cleared
			if (state_q == T_IDLE && in_acc && is_term) begin
				res_match_q <= 1'b0;
				res_err_q   <= ovf_q ? ERR_LONG
					: (star_tot_q > STOT_W'(MAX_STARS)) ? ERR_STARS : ERR_NONE;
			end
			if (state_q == T_WALK && walk.done) begin
				res_match_q <= walk.matched;
				res_err_q   <= ERR_NONE;
				cap_n_q     <= walk.ncap;
				k_q         <= '0;
			end

			if (clear_str) begin
				plen_q     <= '0;
				slen_q     <= '0;
				ovf_q      <= 1'b0;
				star_tot_q <= '0;
			end

			if (load_cap && !cap_last) begin
				k_q <= k_q + 1'b1;
			end

			// result register: advance on take, load on new beat
			if (load_res || load_cap) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (load_res) begin
			matched_q   <= res_match_q;
			err_q       <= res_err_q;
			cap_valid_q <= 1'b0;
			cap_idx_q   <= '0;
			cap_start_q <= '0;
			cap_len_q   <= '0;
			last_q      <= 1'b1;
		end else if (load_cap) begin
			matched_q   <= 1'b1;
			err_q       <= ERR_NONE;
			cap_valid_q <= 1'b1;
			cap_idx_q   <= IDX_W'(k_q);
			cap_start_q <= POS_W'(cap_rd_q[CAP_W-1:LEN_W]);
			cap_len_q   <= POS_W'(cap_rd_q[LEN_W-1:0]);
			last_q      <= cap_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign matched        = matched_q;
	assign error_code     = err_q;
	assign capture_valid  = cap_valid_q;
	assign capture_index  = cap_idx_q;
	assign capture_start  = cap_start_q;
	assign capture_length = cap_len_q;
	assign last_result    = last_q;

	a_walk_done_owned: assert property (@(posedge clk) disable iff (!arst_n)
		walk.done |-> state_q == T_WALK)
		else $error("walk finished outside the walk state");

	a_lengths_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(plen_q <= LEN_W'(MAX_LEN)) && (slen_q <= LEN_W'(MAX_LEN))
		&& (star_tot_q <= STOT_W'(MAX_STARS + 1)))
		else $error("string bookkeeping out of range");

	a_capture_is_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && cap_valid_q |-> matched_q && (err_q == ERR_NONE))
		else $error("capture beat without a clean match");

	a_cap_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == T_CAP_PUSH |-> (k_q < cap_n_q))
		else $error("capture index past star count");

endmodule
